// File: sv/xrs_pkg.sv
// Package for the xoroshiro128++ random source: codes, command/status types, generator math.
`default_nettype none
package xrs_pkg;

	localparam int unsigned WordW  = 64;
	localparam int unsigned HalfW  = 32;
	localparam int unsigned BoundW = 31;
	localparam int unsigned BitsW  = 7;
	localparam int unsigned CountW = 16;
	localparam int unsigned KindW  = 3;
	localparam int unsigned DivCntW = 5;

	localparam logic [WordW-1:0] DefaultLow  = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WordW-1:0] DefaultHigh = 64'h6A09_E667_F3BC_C909;

	// Request codes
	typedef enum logic [KindW-1:0] {
		K_RESEED  = 3'd0,
		K_RAW     = 3'd1,
		K_BOUNDED = 3'd2,
		K_TOPBITS = 3'd3,
		K_BOOL    = 3'd4,
		K_SKIP    = 3'd5
	} kind_t;

	// Configuration register indexes
	typedef enum logic {
		REG_SEED_LOW  = 1'b0,
		REG_SEED_HIGH = 1'b1
	} cfg_reg_t;

	// Generator state update
	typedef enum logic [1:0] {
		GEN_HOLD = 2'd0,
		GEN_STEP = 2'd1,
		GEN_SEED = 2'd2
	} gen_op_t;

	// Result source
	typedef enum logic [2:0] {
		RES_ZERO  = 3'd0,
		RES_RAW   = 3'd1,
		RES_TOP   = 3'd2,
		RES_BOOL  = 3'd3,
		RES_MHIGH = 3'd4
	} res_sel_t;

	typedef struct packed {
		logic     latch_in;
		gen_op_t  gen_op;
		res_sel_t res_sel;
		logic     res_load;
		logic     m_load;
		logic     div_start;
		logic     div_step;
		logic     cnt_dec;
		logic     out_load;
	} xrs_cmd_t;

	typedef struct packed {
		logic [KindW-1:0] kind;
		logic             count_zero;
		logic             m_lt_bound;
		logic             m_lt_limit;
		logic             div_last;
	} xrs_sts_t;

	function automatic logic [WordW-1:0] rotl64(input logic [WordW-1:0] x, input int unsigned k);
		rotl64 = (x << k) | (x >> (WordW - k));
	endfunction

	// Output of one generator step from the current state
	function automatic logic [WordW-1:0] gen_out(input logic [WordW-1:0] lo,
			input logic [WordW-1:0] hi);
		gen_out = rotl64(lo + hi, 17) + lo;
	endfunction

	function automatic logic [WordW-1:0] next_low(input logic [WordW-1:0] lo,
			input logic [WordW-1:0] hi);
		logic [WordW-1:0] t;
		t = hi ^ lo;
		next_low = rotl64(lo, 49) ^ t ^ (t << 21);
	endfunction

	function automatic logic [WordW-1:0] next_high(input logic [WordW-1:0] lo,
			input logic [WordW-1:0] hi);
		next_high = rotl64(hi ^ lo, 28);
	endfunction

	// Top bit_count bits of a value; zero count gives zero, 64 and up gives the whole word
	function automatic logic [WordW-1:0] top_bits(input logic [WordW-1:0] v,
			input logic [BitsW-1:0] n);
		logic [BitsW-1:0] sh;
		sh = BitsW'(WordW) - n;
		if (n == '0) begin
			top_bits = '0;
		end else if (n >= BitsW'(WordW)) begin
			top_bits = v;
		end else begin
			top_bits = v >> sh;
		end
	endfunction

endpackage
`default_nettype wire

// File: sv/xrs_dpath.sv
// Datapath: seed and generator registers, request fields, multiplier, serial remainder unit.
`default_nettype none
module xrs_dpath
	import xrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [WordW-1:0]  cfg_data,
	input  wire logic [KindW-1:0]  kind,
	input  wire logic [BoundW-1:0] bound,
	input  wire logic [BitsW-1:0]  bit_count,
	input  wire logic [CountW-1:0] skip_count,
	input  wire xrs_cmd_t          cmd,
	output xrs_sts_t               sts,
	output logic [WordW-1:0]       value
);

	logic [WordW-1:0]   seed_low_q, seed_high_q;
	logic [WordW-1:0]   gen_low_q, gen_high_q;
	logic [KindW-1:0]   kind_q;
	logic [BoundW-1:0]  bound_q;
	logic [BitsW-1:0]   bits_q;
	logic [CountW-1:0]  count_q;
	logic [WordW-1:0]   m_q;
	logic [HalfW-1:0]   dvd_q;
	logic [BoundW-1:0]  rem_q;
	logic [DivCntW-1:0] div_cnt_q;
	logic [WordW-1:0]   res_q;
	logic [WordW-1:0]   value_q;

	logic [WordW-1:0]   step_out;
	logic [WordW-1:0]   res_d;
	logic [HalfW-1:0]   rem_sh;
	logic               seed_zero;

	assign step_out  = gen_out(gen_low_q, gen_high_q);
	assign seed_zero = (seed_low_q | seed_high_q) == '0;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_low_q  <= '0;
			seed_high_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_SEED_LOW) begin
				seed_low_q <= cfg_data;
			end else begin
				seed_high_q <= cfg_data;
			end
		end
	end

	// Generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_low_q  <= DefaultLow;
			gen_high_q <= DefaultHigh;
		end else begin
			unique case (cmd.gen_op)
				GEN_STEP: begin
					gen_low_q  <= next_low(gen_low_q, gen_high_q);
					gen_high_q <= next_high(gen_low_q, gen_high_q);
				end
				GEN_SEED: begin
					gen_low_q  <= seed_zero ? DefaultLow : seed_low_q;
					gen_high_q <= seed_zero ? DefaultHigh : seed_high_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Request fields and skip counter
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			kind_q  <= kind;
			bound_q <= bound;
			bits_q  <= bit_count;
			count_q <= skip_count;
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - 1'b1;
		end
	end

	// Multiply-high candidate: low half of a step times the bound
	always_ff @(posedge clk) begin
		if (cmd.m_load) begin
			m_q <= WordW'(step_out[HalfW-1:0]) * WordW'(bound_q);
		end
	end

	// Restoring remainder of (2^32 - bound) by bound, one bit a cycle
	assign rem_sh = {rem_q, dvd_q[HalfW-1]};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dvd_q     <= HalfW'(0) - HalfW'(bound_q);
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			dvd_q     <= dvd_q << 1;
			div_cnt_q <= div_cnt_q + 1'b1;
			if (rem_sh >= HalfW'(bound_q)) begin
				rem_q <= BoundW'(rem_sh - HalfW'(bound_q));
			end else begin
				rem_q <= rem_sh[BoundW-1:0];
			end
		end
	end

	// Result select
	always_comb begin
		case (cmd.res_sel)
			RES_RAW:   res_d = step_out;
			RES_TOP:   res_d = top_bits(step_out, bits_q);
			RES_BOOL:  res_d = WordW'(step_out[0]);
			RES_MHIGH: res_d = WordW'(m_q[WordW-1:HalfW]);
			default:   res_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= res_d;
		end
		if (cmd.out_load) begin
			value_q <= res_q;
		end
	end

	assign value = value_q;

	// Status toward the controller
	assign sts.kind       = kind_q;
	assign sts.count_zero = count_q == '0;
	assign sts.m_lt_bound = m_q[HalfW-1:0] < HalfW'(bound_q);
	assign sts.m_lt_limit = m_q[HalfW-1:0] < HalfW'(rem_q);
	assign sts.div_last   = div_cnt_q == {DivCntW{1'b1}};

endmodule
`default_nettype wire

// File: sv/xrs_ctrl.sv
// Controller: request sequencing state machine and output handshake.
`default_nettype none
module xrs_ctrl
	import xrs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire logic     out_stall,
	input  wire xrs_sts_t sts,
	output xrs_cmd_t      cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_EXEC  = 6'b000010,
		ST_CHECK = 6'b000100,
		ST_DIV   = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || !out_stall;

	// Next state and datapath commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.gen_op  = GEN_HOLD;
		cmd.res_sel = RES_ZERO;
		in_stall    = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (sts.kind)
					K_RESEED: begin
						cmd.gen_op   = GEN_SEED;
						cmd.res_load = 1'b1;
						state_d      = ST_DONE;
					end
					K_RAW: begin
						cmd.gen_op   = GEN_STEP;
						cmd.res_sel  = RES_RAW;
						cmd.res_load = 1'b1;
						state_d      = ST_DONE;
					end
					K_TOPBITS: begin
						cmd.gen_op   = GEN_STEP;
						cmd.res_sel  = RES_TOP;
						cmd.res_load = 1'b1;
						state_d      = ST_DONE;
					end
					K_BOOL: begin
						cmd.gen_op   = GEN_STEP;
						cmd.res_sel  = RES_BOOL;
						cmd.res_load = 1'b1;
						state_d      = ST_DONE;
					end
					K_BOUNDED: begin
						cmd.gen_op = GEN_STEP;
						cmd.m_load = 1'b1;
						state_d    = ST_CHECK;
					end
					K_SKIP: begin
						if (sts.count_zero) begin
							cmd.res_load = 1'b1;
							state_d      = ST_DONE;
						end else begin
							cmd.gen_op  = GEN_STEP;
							cmd.cnt_dec = 1'b1;
						end
					end
					default: begin
						cmd.res_load = 1'b1;
						state_d      = ST_DONE;
					end
				endcase
			end
			ST_CHECK: begin
				// Only a low product below the bound needs the rejection limit
				if (sts.m_lt_bound) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.res_sel  = RES_MHIGH;
					cmd.res_load = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				// Redraw while the low product falls below the limit
				if (sts.m_lt_limit) begin
					cmd.gen_op = GEN_STEP;
					cmd.m_load = 1'b1;
				end else begin
					cmd.res_sel  = RES_MHIGH;
					cmd.res_load = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				// Hand the result over and take the next request in the same cycle
				if (slot_free) begin
					cmd.out_load = 1'b1;
					in_stall     = 1'b0;
					if (in_valid) begin
						cmd.latch_in = 1'b1;
						state_d      = ST_EXEC;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	// Busy states never take a request
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC || state_q == ST_CHECK || state_q == ST_DIV || state_q == ST_CMP)
		|-> in_stall)
		else $error("request taken while busy");

	// A new result only appears from the done state
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result shown without completion");

	// The remainder unit runs its full length
	a_div_run: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.div_last) |=> state_q == ST_DIV)
		else $error("remainder sequence cut short");

	// A completed result is never overwritten while stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !cmd.out_load)
		else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// File: sv/xoroshiro128pp_random_source.sv
// Top level of the xoroshiro128++ random source: controller plus datapath.
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    kind, bound, bit_count, skip_count
//  out      source     out_valid / out_stall  value
//  cfg      sink       cfg_we                 cfg_index, cfg_data
//
// Raw, top-bits, boolean and reseed requests run back to back while the output is free:
// one generator step or reseed, then a move of the result into the output register.
// Bounded requests check the candidate product and, when it falls below the bound, run the
// serial remainder unit, then redraw while below the limit. Skip steps the generator count times.
// Reset restores the default nonzero generator state and zero seeds.
// A stalled output holds its value; one more request is taken and run, then its
// result and any later request wait until the output frees.
`default_nettype none
module xoroshiro128pp_random_source
	import xrs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic              cfg_index,
	input  wire logic [WordW-1:0]  cfg_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [KindW-1:0]  kind,
	input  wire logic [BoundW-1:0] bound,
	input  wire logic [BitsW-1:0]  bit_count,
	input  wire logic [CountW-1:0] skip_count,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WordW-1:0]       value
);

	xrs_cmd_t cmd;
	xrs_sts_t sts;

	xrs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	xrs_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.kind       (kind),
		.bound      (bound),
		.bit_count  (bit_count),
		.skip_count (skip_count),
		.cmd        (cmd),
		.sts        (sts),
		.value      (value)
	);

endmodule
`default_nettype wire

// File: verif/xrs_value_checker.sv
// Checker for the xoroshiro128++ random source: predicts each request's value and compares.
module xrs_value_checker
	import xrs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WordW-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [KindW-1:0]  kind,
	input  logic [BoundW-1:0] bound,
	input  logic [BitsW-1:0]  bit_count,
	input  logic [CountW-1:0] skip_count,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [WordW-1:0]  value,
	output int unsigned       errors,
	output int unsigned       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow generator and seed registers
	logic [WordW-1:0] seed_lo;
	logic [WordW-1:0] seed_hi;
	logic [WordW-1:0] gen_lo;
	logic [WordW-1:0] gen_hi;

	// Values owed for accepted requests, oldest first
	logic [WordW-1:0] owed_values[$];
	logic [WordW-1:0] owed;
	int unsigned      fail_count;

	function automatic logic [WordW-1:0] rol64(input logic [WordW-1:0] x, input int unsigned k);
		rol64 = (x << k) | (x >> (64 - k));
	endfunction

	// One generator draw: returns the output word and advances the shadow state
	function automatic logic [WordW-1:0] draw_word();
		logic [WordW-1:0] t;
		draw_word = rol64(gen_lo + gen_hi, 17) + gen_lo;
		t = gen_hi ^ gen_lo;
		gen_lo = rol64(gen_lo, 49) ^ t ^ (t << 21);
		gen_hi = rol64(t, 28);
	endfunction

	// Value returned for one request; updates the shadow state as the block should
	function automatic logic [WordW-1:0] serve_request(input logic [KindW-1:0] k,
			input logic [BoundW-1:0] b, input logic [BitsW-1:0] n, input logic [CountW-1:0] c);
		logic [WordW-1:0] w;
		logic [WordW-1:0] prod;
		logic [31:0]      lim;
		serve_request = '0;
		case (k)
			K_RESEED: begin
				if ((seed_lo | seed_hi) == '0) begin
					gen_lo = DefaultLow;
					gen_hi = DefaultHigh;
				end else begin
					gen_lo = seed_lo;
					gen_hi = seed_hi;
				end
			end
			K_RAW: serve_request = draw_word();
			K_BOUNDED: begin
				w = draw_word();
				prod = 64'(w[31:0]) * 64'(b);
				// redraw only when the low half falls below the rejection threshold
				if (b != '0 && prod[31:0] < 32'(b)) begin
					lim = (32'h0 - 32'(b)) % 32'(b);
					while (prod[31:0] < lim) begin
						w = draw_word();
						prod = 64'(w[31:0]) * 64'(b);
					end
				end
				serve_request = prod >> 32;
			end
			K_TOPBITS: begin
				w = draw_word();
				if (n == '0)
					serve_request = '0;
				else if (n >= 64)
					serve_request = w;
				else
					serve_request = w >> (64 - n);
			end
			K_BOOL: begin
				w = draw_word();
				serve_request = {63'b0, w[0]};
			end
			K_SKIP: begin
				repeat (c) w = draw_word();
			end
			default: ;
		endcase
	endfunction

	// Config shadowing, request prediction and result comparison
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_lo = '0;
			seed_hi = '0;
			gen_lo = DefaultLow;
			gen_hi = DefaultHigh;
			owed_values.delete();
			fail_count = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_SEED_LOW)
					seed_lo = cfg_data;
				else
					seed_hi = cfg_data;
			end
			if (out_valid && !out_stall) begin
				if (owed_values.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result value %h", $realtime, value);
					fail_count++;
				end else begin
					owed = owed_values.pop_front();
					if (owed !== value) begin
						if (fail_count < 10)
							$display("%0t: value mismatch: expected %h, got %h",
								$realtime, owed, value);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				owed_values.push_back(serve_request(kind, bound, bit_count, skip_count));
			errors <= fail_count;
			pending <= owed_values.size();
		end
	end

endmodule

// File: verif/xoroshiro128pp_random_source_tb.sv
// Testbench top for the xoroshiro128++ random source: clock, reset, stimulus and verdict.
module xoroshiro128pp_random_source_tb
	import xrs_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Kind codes the block does not define
	localparam logic [KindW-1:0] K_SPARE6 = 3'd6;
	localparam logic [KindW-1:0] K_SPARE7 = 3'd7;
	// Longest legal quiet stretch is a full 16-bit skip
	localparam int unsigned IdleLimit = 200000;
	localparam int unsigned RandPerPhase = 230;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic              cfg_index;
	logic [WordW-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [KindW-1:0]  kind;
	logic [BoundW-1:0] bound;
	logic [BitsW-1:0]  bit_count;
	logic [CountW-1:0] skip_count;
	logic              out_valid;
	logic              out_stall;
	logic [WordW-1:0]  value;
	int unsigned       errors;
	int unsigned       pending;
	bit                bursts_on;
	int unsigned       big_skips;

	xoroshiro128pp_random_source u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.bound      (bound),
		.bit_count  (bit_count),
		.skip_count (skip_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value)
	);

	xrs_value_checker u_value_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.bound      (bound),
		.bit_count  (bit_count),
		.skip_count (skip_count),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.errors     (errors),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Result-side stall bursts, with quiet stretches in between
	initial begin
		int unsigned n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (bursts_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 12);
				out_stall <= 1'b1;
				repeat (n) @(negedge clk);
				out_stall <= 1'b0;
			end else if ($urandom_range(0, 15) == 0) begin
				out_stall <= 1'b0;
				repeat ($urandom_range(20, 80)) @(negedge clk);
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles without any handshake
	initial begin
		int unsigned idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle = 0;
			else
				idle++;
			if (idle >= IdleLimit) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Present one request, with an optional idle gap ahead of it
	task automatic send_req(input logic [KindW-1:0] k, input logic [BoundW-1:0] b,
			input logic [BitsW-1:0] n, input logic [CountW-1:0] c);
		int unsigned gap;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= k;
		bound <= b;
		bit_count <= n;
		skip_count <= c;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait for every owed value to come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic load_seeds(input logic [WordW-1:0] lo, input logic [WordW-1:0] hi);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SEED_LOW;
		cfg_data <= lo;
		@(negedge clk);
		cfg_index <= REG_SEED_HIGH;
		cfg_data <= hi;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Field extremes, every kind and the corner cases
	task automatic directed_reqs();
		send_req(K_RAW, '1, '1, '1);
		send_req(K_TOPBITS, '0, 7'd64, '0);
		send_req(K_TOPBITS, '1, 7'd1, '1);
		send_req(K_TOPBITS, '0, 7'd0, '0);
		send_req(K_TOPBITS, '0, 7'd127, '0);
		send_req(K_TOPBITS, '0, 7'd63, '0);
		send_req(K_BOOL, '0, '0, '0);
		send_req(K_BOUNDED, 31'd1, '0, '0);
		send_req(K_BOUNDED, 31'd0, '0, '0);
		send_req(K_BOUNDED, 31'h7FFF_FFFF, '0, '0);
		send_req(K_BOUNDED, 31'h6000_0000, '0, '0);
		send_req(K_BOUNDED, 31'h6000_0000, '0, '0);
		send_req(K_BOUNDED, 31'd3, '1, '1);
		send_req(K_SKIP, '0, '0, 16'd0);
		send_req(K_SKIP, '1, '1, 16'd1);
		send_req(K_SKIP, '0, '0, 16'hFFFF);
		send_req(K_SPARE6, '1, '1, '1);
		send_req(K_SPARE7, '0, '0, '0);
		send_req(K_RESEED, '0, '0, '0);
		send_req(K_RAW, '0, '0, '0);
		send_req(K_RAW, '0, '0, '0);
	endtask

	// Mostly well-formed requests with random content; unused fields carry noise
	task automatic random_req();
		logic [KindW-1:0]  k;
		logic [BoundW-1:0] b;
		logic [BitsW-1:0]  n;
		logic [CountW-1:0] c;
		int unsigned       sel;
		int unsigned       pick;
		sel = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		b = BoundW'($urandom);
		n = BitsW'($urandom);
		c = CountW'($urandom);
		if (sel < 4) begin
			k = K_RESEED;
		end else if (sel < 24) begin
			k = K_RAW;
		end else if (sel < 50) begin
			k = K_BOUNDED;
			// large bounds make rejection likely
			case (pick)
				0: b = BoundW'($urandom_range(1, 4));
				1: b = 31'h7FFF_FFFF - BoundW'($urandom_range(0, 3));
				2, 3, 4: b = BoundW'($urandom_range(32'h4000_0001, 32'h7FFF_FFFF));
				5: b = ($urandom_range(0, 3) == 0) ? '0 : BoundW'($urandom_range(1, 1000));
				default: ;
			endcase
		end else if (sel < 70) begin
			k = K_TOPBITS;
			case (pick)
				0: n = 7'd0;
				1: n = 7'd64;
				2: n = BitsW'($urandom_range(65, 127));
				default: n = BitsW'($urandom_range(1, 63));
			endcase
		end else if (sel < 85) begin
			k = K_BOOL;
		end else if (sel < 97) begin
			k = K_SKIP;
			// a few full-range skips, the rest short
			if (big_skips < 3 && $urandom_range(0, 299) == 0)
				big_skips++;
			else
				c = CountW'($urandom_range(0, 20));
		end else begin
			k = ($urandom_range(0, 1) == 0) ? K_SPARE6 : K_SPARE7;
		end
		send_req(k, b, n, c);
	endtask

	initial begin
		logic [WordW-1:0] lo_seeds[6];
		logic [WordW-1:0] hi_seeds[6];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SEED_LOW;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = K_RESEED;
		bound = '0;
		bit_count = '0;
		skip_count = '0;
		bursts_on = 1'b1;
		big_skips = 0;

		// seed settings per phase: all ones, one word zero, tiny, random, back to zero
		lo_seeds[0] = '1;                   hi_seeds[0] = '1;
		lo_seeds[1] = {$urandom, $urandom}; hi_seeds[1] = '0;
		lo_seeds[2] = '0;                   hi_seeds[2] = {$urandom, $urandom};
		lo_seeds[3] = 64'd1;                hi_seeds[3] = '0;
		lo_seeds[4] = {$urandom, $urandom}; hi_seeds[4] = {$urandom, $urandom};
		lo_seeds[5] = '0;                   hi_seeds[5] = '0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		load_seeds('0, '0);
		directed_reqs();
		drain();

		for (int p = 0; p < 6; p++) begin
			// final phase runs without any idling
			if (p == 5)
				bursts_on = 1'b0;
			load_seeds(lo_seeds[p], hi_seeds[p]);
			send_req(K_RESEED, BoundW'($urandom), BitsW'($urandom), CountW'($urandom));
			repeat (RandPerPhase) random_req();
			drain();
		end

		repeat (40) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
